// File: rtl/twc_pkg.sv
package twc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // Calibration point widths.
    localparam int W_W = 14;
    localparam int C_W = 16;

    // Point one weight times the ADC span.
    localparam int PROD1_W = W_W + C_W;

    localparam int WEIGHT_W = 32;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P1_WEIGHT = 2'd0,
        CFG_P1_COUNT  = 2'd1,
        CFG_P2_WEIGHT = 2'd2,
        CFG_P2_COUNT  = 2'd3
    } cfg_reg_t;

endpackage

// File: rtl/twc_div.sv
module twc_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 14,
    parameter int SB_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [SB_W-1:0]  sb_out
);

    // One restoring step per stage: the numerator shifts out at the top of
    // the shift register while quotient bits shift in at the bottom.
    logic             v_reg   [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             v_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [DEN_W-1:0] den_prev;
        logic [NUM_W-1:0] nq_prev;
        logic [SB_W-1:0]  sb_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (k == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = '0;
            assign den_prev = den;
            assign nq_prev  = num;
            assign sb_prev  = sb_in;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign nq_prev  = nq_reg[k-1];
            assign sb_prev  = sb_reg[k-1];
        end

        assign trial    = {rem_prev, nq_prev[NUM_W-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign ge       = (trial >= {1'b0, den_prev});
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {nq_prev[NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
                nq_reg[k]  <= nq_next;
                sb_reg[k]  <= sb_prev;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign sb_out    = sb_reg[NUM_W-1];

endmodule

// File: rtl/twc_prep.sv
module twc_prep import twc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [W_W-1:0]         w1,
    input  logic [C_W-1:0]         cnt1,
    input  logic [W_W-1:0]         w2,
    input  logic [C_W-1:0]         cnt2,
    output logic                   out_valid,
    output logic [PROD1_W-1:0]     prod,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic [C_W-1:0]         out_cnt1,
    output logic [C_W-1:0]         out_adc_span,
    output logic [W_W-1:0]         out_wspan,
    output logic                   out_err
);

    logic                   va_reg;
    logic [SAMPLE_BITS-1:0] sample_a_reg;
    logic [W_W-1:0]         w1_a_reg;
    logic [C_W-1:0]         cnt1_a_reg;
    logic [C_W-1:0]         adc_a_reg;
    logic [W_W-1:0]         wspan_a_reg;
    logic                   err_a_reg;

    logic                   vb_reg;
    logic [PROD1_W-1:0]     prod_b_reg;
    logic [SAMPLE_BITS-1:0] sample_b_reg;
    logic [C_W-1:0]         cnt1_b_reg;
    logic [C_W-1:0]         adc_b_reg;
    logic [W_W-1:0]         wspan_b_reg;
    logic                   err_b_reg;

    logic                   cnt_gt;
    logic                   cnt_ge;
    logic [W_W:0]           diff_next;
    logic [C_W-1:0]         adc_next;
    logic                   err_next;
    logic [PROD1_W-1:0]     prod_next;

    // The weight span follows the order of the count difference.
    assign cnt_gt    = (cnt1 > cnt2);
    assign cnt_ge    = (cnt1 >= cnt2);
    assign diff_next = cnt_ge ? ({1'b0, w1} - {1'b0, w2}) : ({1'b0, w2} - {1'b0, w1});
    assign adc_next  = cnt_gt ? (cnt1 - cnt2) : (cnt_ge ? C_W'(1) : (cnt2 - cnt1));
    assign err_next  = diff_next[W_W] || (diff_next == '0);
    assign prod_next = {{C_W{1'b0}}, w1_a_reg} * {{W_W{1'b0}}, adc_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_a_reg <= sample;
            w1_a_reg     <= w1;
            cnt1_a_reg   <= cnt1;
            adc_a_reg    <= adc_next;
            wspan_a_reg  <= diff_next[W_W-1:0];
            err_a_reg    <= err_next;
            prod_b_reg   <= prod_next;
            sample_b_reg <= sample_a_reg;
            cnt1_b_reg   <= cnt1_a_reg;
            adc_b_reg    <= adc_a_reg;
            wspan_b_reg  <= wspan_a_reg;
            err_b_reg    <= err_a_reg;
        end
    end

    assign out_valid    = vb_reg;
    assign prod         = prod_b_reg;
    assign out_sample   = sample_b_reg;
    assign out_cnt1     = cnt1_b_reg;
    assign out_adc_span = adc_b_reg;
    assign out_wspan    = wspan_b_reg;
    assign out_err      = err_b_reg;

endmodule

// File: rtl/twc_net.sv
module twc_net import twc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int NET_W       = PROD1_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [PROD1_W-1:0]     offset,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [C_W-1:0]         cnt1,
    input  logic [C_W-1:0]         adc_span,
    input  logic [W_W-1:0]         wspan,
    input  logic                   err,
    output logic                   out_valid,
    output logic [NET_W+W_W-1:0]   prod,
    output logic [C_W-1:0]         out_adc_span,
    output logic                   out_below,
    output logic                   out_err
);

    logic                   va_reg;
    logic [PROD1_W-1:0]     zmag_a_reg;
    logic                   zneg_a_reg;
    logic [SAMPLE_BITS-1:0] sample_a_reg;
    logic [C_W-1:0]         adc_a_reg;
    logic [W_W-1:0]         wspan_a_reg;
    logic                   err_a_reg;

    logic                   vb_reg;
    logic [NET_W-1:0]       net_b_reg;
    logic                   below_b_reg;
    logic [C_W-1:0]         adc_b_reg;
    logic [W_W-1:0]         wspan_b_reg;
    logic                   err_b_reg;

    logic                   vc_reg;
    logic [NET_W+W_W-1:0]   prod_c_reg;
    logic [C_W-1:0]         adc_c_reg;
    logic                   below_c_reg;
    logic                   err_c_reg;

    logic [PROD1_W-1:0]     cnt1_ext;
    logic                   zneg_next;
    logic [PROD1_W-1:0]     zmag_next;
    logic [NET_W-1:0]       sample_ext;
    logic [NET_W-1:0]       zmag_ext;
    logic [NET_W-1:0]       net_next;
    logic                   below_next;
    logic [NET_W+W_W-1:0]   prod_next;

    // The zero point is held as magnitude plus sign.
    assign cnt1_ext  = PROD1_W'(cnt1);
    assign zneg_next = (cnt1_ext < offset);
    assign zmag_next = zneg_next ? (offset - cnt1_ext) : (cnt1_ext - offset);

    assign sample_ext = NET_W'(sample_a_reg);
    assign zmag_ext   = NET_W'(zmag_a_reg);

    always_comb
    begin
        below_next = 1'b0;
        if (zneg_a_reg)
        begin
            net_next = sample_ext + zmag_ext;
        end
        else if (sample_ext >= zmag_ext)
        begin
            net_next = sample_ext - zmag_ext;
        end
        else
        begin
            net_next   = zmag_ext - sample_ext;
            below_next = 1'b1;
        end
    end

    assign prod_next = {{W_W{1'b0}}, net_b_reg} * {{NET_W{1'b0}}, wspan_b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zmag_a_reg   <= zmag_next;
            zneg_a_reg   <= zneg_next;
            sample_a_reg <= sample;
            adc_a_reg    <= adc_span;
            wspan_a_reg  <= wspan;
            err_a_reg    <= err;
            net_b_reg    <= net_next;
            below_b_reg  <= below_next;
            adc_b_reg    <= adc_a_reg;
            wspan_b_reg  <= wspan_a_reg;
            err_b_reg    <= err_a_reg;
            prod_c_reg   <= prod_next;
            adc_c_reg    <= adc_b_reg;
            below_c_reg  <= below_b_reg;
            err_c_reg    <= err_b_reg;
        end
    end

    assign out_valid    = vc_reg;
    assign prod         = prod_c_reg;
    assign out_adc_span = adc_c_reg;
    assign out_below    = below_c_reg;
    assign out_err      = err_c_reg;

endmodule

// File: rtl/two_point_weight_conversion.sv
// Two-point load-cell weight conversion.
// Four calibration registers (two weights, two ADC counts) are written
// through cfg_we / cfg_index / cfg_data; the user must write them only
// while no sample is in flight, which the block does not enforce.
// Samples enter on adc_sample with in_valid / in_stall; each sample gives
// exactly one word on weight_value, below_zero and span_error with
// out_valid / out_stall. A sample passes the preparation stages, two
// bit-per-stage restoring dividers with the net stages between them
// (30 stages for the zero point offset, NET_W + 14 for the final
// weight, NET_W being the larger of SAMPLE_BITS and 30, plus one) and
// the output register. One sample is taken every cycle as long as the
// output is not stalled. All stages advance together; while out_stall
// holds a valid word, the whole pipeline freezes and in_stall is raised,
// so nothing is lost or repeated. Reset clears all valid bits and sets
// the calibration registers to zero.
module two_point_weight_conversion import twc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [C_W-1:0]         cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WEIGHT_W-1:0]    weight_value,
    output logic                   below_zero,
    output logic                   span_error
);

    localparam int NET_W   = ((SAMPLE_BITS > PROD1_W) ? SAMPLE_BITS : PROD1_W) + 1;
    localparam int PROD2_W = NET_W + W_W;
    localparam int SB1_W   = SAMPLE_BITS + C_W + C_W + W_W + 1;

    logic [W_W-1:0] w1_reg;
    logic [C_W-1:0] cnt1_reg;
    logic [W_W-1:0] w2_reg;
    logic [C_W-1:0] cnt2_reg;

    logic           en;

    logic                   p_valid;
    logic [PROD1_W-1:0]     p_prod;
    logic [SAMPLE_BITS-1:0] p_sample;
    logic [C_W-1:0]         p_cnt1;
    logic [C_W-1:0]         p_adc;
    logic [W_W-1:0]         p_wspan;
    logic                   p_err;

    logic                   d1_valid;
    logic [PROD1_W-1:0]     d1_quo;
    logic [SB1_W-1:0]       d1_sb;
    logic [SAMPLE_BITS-1:0] d1_sample;
    logic [C_W-1:0]         d1_cnt1;
    logic [C_W-1:0]         d1_adc;
    logic [W_W-1:0]         d1_wspan;
    logic                   d1_err;

    logic                   n_valid;
    logic [PROD2_W-1:0]     n_prod;
    logic [C_W-1:0]         n_adc;
    logic                   n_below;
    logic                   n_err;

    logic                   d2_valid;
    logic [PROD2_W-1:0]     d2_quo;
    logic [1:0]             d2_sb;

    logic                   out_valid_reg;
    logic [WEIGHT_W-1:0]    weight_reg;
    logic                   below_reg;
    logic                   err_reg;

    logic [WEIGHT_W-1:0]    weight_next;
    logic                   sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg   <= '0;
            cnt1_reg <= '0;
            w2_reg   <= '0;
            cnt2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_P1_WEIGHT: w1_reg   <= cfg_data[W_W-1:0];
                CFG_P1_COUNT:  cnt1_reg <= cfg_data;
                CFG_P2_WEIGHT: w2_reg   <= cfg_data[W_W-1:0];
                CFG_P2_COUNT:  cnt2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output word is empty or being taken.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    twc_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .sample       (adc_sample),
        .w1           (w1_reg),
        .cnt1         (cnt1_reg),
        .w2           (w2_reg),
        .cnt2         (cnt2_reg),
        .out_valid    (p_valid),
        .prod         (p_prod),
        .out_sample   (p_sample),
        .out_cnt1     (p_cnt1),
        .out_adc_span (p_adc),
        .out_wspan    (p_wspan),
        .out_err      (p_err)
    );

    // A bad weight span divides by one; the result is discarded anyway.
    twc_div #(
        .NUM_W (PROD1_W),
        .DEN_W (W_W),
        .SB_W  (SB1_W)
    ) u_div_zero (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .num       (p_prod),
        .den       (p_err ? W_W'(1) : p_wspan),
        .sb_in     ({p_sample, p_cnt1, p_adc, p_wspan, p_err}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .sb_out    (d1_sb)
    );

    assign {d1_sample, d1_cnt1, d1_adc, d1_wspan, d1_err} = d1_sb;

    twc_net #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NET_W       (NET_W)
    ) u_net (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (d1_valid),
        .offset       (d1_quo),
        .sample       (d1_sample),
        .cnt1         (d1_cnt1),
        .adc_span     (d1_adc),
        .wspan        (d1_wspan),
        .err          (d1_err),
        .out_valid    (n_valid),
        .prod         (n_prod),
        .out_adc_span (n_adc),
        .out_below    (n_below),
        .out_err      (n_err)
    );

    twc_div #(
        .NUM_W (PROD2_W),
        .DEN_W (C_W),
        .SB_W  (2)
    ) u_div_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid),
        .num       (n_prod),
        .den       (n_adc),
        .sb_in     ({n_below, n_err}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .sb_out    (d2_sb)
    );

    assign sat         = |d2_quo[PROD2_W-1:WEIGHT_W];
    assign weight_next = d2_sb[0] ? '0 : (sat ? '1 : d2_quo[WEIGHT_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= weight_next;
            below_reg  <= d2_sb[1] && !d2_sb[0];
            err_reg    <= d2_sb[0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign weight_value = weight_reg;
    assign below_zero   = below_reg;
    assign span_error   = err_reg;

endmodule

// File: rtl/twc_check.sv
module twc_check import twc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [WEIGHT_W-1:0] weight_value,
    input logic                below_zero,
    input logic                span_error
);

    // The input is only held back by a word that is waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting output word");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && span_error) |-> (weight_value == '0 && !below_zero))
        else $error("span error word carries a weight or below flag");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(weight_value) && $stable(below_zero))
        else $error("output word changed while stalled");

endmodule

bind two_point_weight_conversion twc_check u_check (.*);

// File: bench/tb_two_point_weight_conversion.sv
module tb_two_point_weight_conversion;
    import twc_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                below;
        logic                err;
    } weight_word_t;

    // A row either loads a new calibration or sends one sample.
    typedef struct {
        bit             is_cal;
        logic [C_W-1:0] w1;
        logic [C_W-1:0] c1;
        logic [C_W-1:0] w2;
        logic [C_W-1:0] c2;
        logic [SB-1:0]  sample;
        bit             has_expect;
        weight_word_t   word;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [C_W-1:0]       cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SB-1:0]        adc_sample;
    logic                 out_valid;
    logic                 out_stall;
    logic [WEIGHT_W-1:0]  weight_value;
    logic                 below_zero;
    logic                 span_error;

    logic [W_W-1:0] cal_w1, cal_w2;
    logic [C_W-1:0] cal_c1, cal_c2;

    weight_word_t pending_weights[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  sink_enable;

    two_point_weight_conversion u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .weight_value(weight_value), .below_zero(below_zero), .span_error(span_error)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [C_W-1:0] rand_word(int unsigned lo, int unsigned hi);
        return C_W'($urandom_range(hi, lo));
    endfunction

    function automatic stim_row_t cal_row(logic [C_W-1:0] w1, logic [C_W-1:0] c1,
                                          logic [C_W-1:0] w2, logic [C_W-1:0] c2);
        stim_row_t r;
        r = '{1'b1, w1, c1, w2, c2, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t sample_row(logic [SB-1:0] s, bit has_exp,
                                             weight_word_t w);
        stim_row_t r;
        r = '{1'b0, '0, '0, '0, '0, s, has_exp, w};
        return r;
    endfunction

    function automatic weight_word_t convert_sample(logic [SB-1:0] s);
        longint unsigned adc_span, offset, zero_mag, net, w, uspan;
        longint unsigned c1, c2, w1, sv;
        longint          wspan;
        bit              zero_neg;
        weight_word_t    r;
        r = '0;
        c1 = 64'(cal_c1);
        c2 = 64'(cal_c2);
        w1 = 64'(cal_w1);
        sv = 64'(s);
        if (c1 > c2)
        begin
            adc_span = c1 - c2;
            wspan = longint'(cal_w1) - longint'(cal_w2);
        end
        else if (c1 == c2)
        begin
            adc_span = 64'd1;
            wspan = longint'(cal_w1) - longint'(cal_w2);
        end
        else
        begin
            adc_span = c2 - c1;
            wspan = longint'(cal_w2) - longint'(cal_w1);
        end
        if (wspan <= 0)
        begin
            r.err = 1'b1;
            return r;
        end
        uspan = wspan;
        offset = (w1 * adc_span) / uspan;
        zero_neg = offset > c1;
        zero_mag = zero_neg ? offset - c1 : c1 - offset;
        if (zero_neg)
            net = sv + zero_mag;
        else if (sv >= zero_mag)
            net = sv - zero_mag;
        else
        begin
            net = zero_mag - sv;
            r.below = 1'b1;
        end
        w = (net * uspan) / adc_span;
        r.weight = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
        return r;
    endfunction

    task automatic write_cal(cfg_reg_t idx, logic [C_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_P1_WEIGHT: cal_w1 = val[W_W-1:0];
            CFG_P1_COUNT:  cal_c1 = val;
            CFG_P2_WEIGHT: cal_w2 = val[W_W-1:0];
            CFG_P2_COUNT:  cal_c2 = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic calibrate(logic [C_W-1:0] w1, logic [C_W-1:0] c1,
                             logic [C_W-1:0] w2, logic [C_W-1:0] c2);
        in_valid = 1'b0;
        wait (pending_weights.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_cal(CFG_P1_WEIGHT, w1);
        write_cal(CFG_P1_COUNT, c1);
        write_cal(CFG_P2_WEIGHT, w2);
        write_cal(CFG_P2_COUNT, c2);
    endtask

    // Holds the word until accepted; expectation is queued at the accepting edge.
    task automatic send_sample(logic [SB-1:0] s, bit has_exp, weight_word_t exp_word);
        weight_word_t e;
        int           gap;
        gap = $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        e = has_exp ? exp_word : convert_sample(s);
        in_valid   = 1'b1;
        adc_sample = s;
        do @(posedge clk); while (in_stall);
        pending_weights.push_back(e);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_weights.size() == 0)
            begin
                $display("%0t: unexpected word weight=%h below=%b err=%b",
                         $time, weight_value, below_zero, span_error);
                failures++;
            end
            else
            begin
                weight_word_t e;
                e = pending_weights.pop_front();
                if (e.weight !== weight_value)
                begin
                    $display("%0t: weight_value expected %h actual %h", $time, e.weight, weight_value);
                    failures++;
                end
                if (e.below !== below_zero)
                begin
                    $display("%0t: below_zero expected %b actual %b", $time, e.below, below_zero);
                    failures++;
                end
                if (e.err !== span_error)
                begin
                    $display("%0t: span_error expected %b actual %b", $time, e.err, span_error);
                    failures++;
                end
            end
        end
    end

    // Output stall: random stall periods, only while sink_enable is set.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = sink_enable ? $urandom_range(0, 6) : 0;
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [SB-1:0] s;
        sink_enable = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_P1_WEIGHT;
        cfg_data = '0;
        in_valid = 1'b0;
        adc_sample = '0;
        cal_w1 = '0; cal_w2 = '0; cal_c1 = '0; cal_c2 = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // After reset both weights are zero, so the span is bad.
        rows.push_back(sample_row(16'h0000, 1'b1, '{32'd0, 1'b0, 1'b1}));
        rows.push_back(sample_row(16'hFFFF, 1'b1, '{32'd0, 1'b0, 1'b1}));
        // Ordinary rising calibration.
        rows.push_back(cal_row(16'd0, 16'd1000, 16'd9999, 16'd51000));
        rows.push_back(sample_row(16'h0000, 1'b1, '{32'd199, 1'b1, 1'b0}));
        rows.push_back(sample_row(16'd1000, 1'b0, '0));
        rows.push_back(sample_row(16'd51000, 1'b0, '0));
        rows.push_back(sample_row(16'hFFFF, 1'b0, '0));
        rows.push_back(sample_row(16'd999, 1'b0, '0));
        rows.push_back(sample_row(16'h5555, 1'b0, '0));
        rows.push_back(sample_row(16'hAAAA, 1'b0, '0));
        // Equal counts with a positive span, a negative zero and a huge product.
        rows.push_back(cal_row(16'h3FFF, 16'd0, 16'd0, 16'd0));
        rows.push_back(sample_row(16'h0000, 1'b0, '0));
        rows.push_back(sample_row(16'hFFFF, 1'b1, '{32'h3FFF_0000, 1'b0, 1'b0}));
        // Equal counts, reversed order gives a bad span.
        rows.push_back(cal_row(16'd5, 16'd300, 16'd9, 16'd300));
        rows.push_back(sample_row(16'd7, 1'b1, '{32'd0, 1'b0, 1'b1}));
        // Falling counts, zero point negative.
        rows.push_back(cal_row(16'd9999, 16'd1000, 16'd9000, 16'd0));
        rows.push_back(sample_row(16'd0, 1'b0, '0));
        rows.push_back(sample_row(16'hFFFF, 1'b0, '0));
        // Data bits above the weight width are dropped.
        rows.push_back(cal_row(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        rows.push_back(sample_row(16'h8000, 1'b0, '0));
        rows.push_back(sample_row(16'h0001, 1'b0, '0));

        foreach (rows[i])
        begin
            if (rows[i].is_cal)
                calibrate(rows[i].w1, rows[i].c1, rows[i].w2, rows[i].c2);
            else
                send_sample(rows[i].sample, rows[i].has_expect, rows[i].word);
        end

        sink_enable = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: calibrate(rand_word(0, 9999), rand_word(0, 65535),
                                 rand_word(0, 9999), rand_word(0, 65535));
                    1: calibrate(rand_word(0, 200), rand_word(0, 4000),
                                 rand_word(5000, 9999), rand_word(40000, 65535));
                    2: calibrate(rand_word(5000, 9999), rand_word(40000, 65535),
                                 rand_word(0, 200), rand_word(0, 4000));
                    3: calibrate(rand_word(0, 65535), rand_word(0, 65535),
                                 rand_word(0, 65535), rand_word(0, 65535));
                    default: calibrate(rand_word(1000, 9999), rand_word(0, 65535),
                                       rand_word(0, 999), rand_word(0, 65535));
                endcase
            end
            s = SB'($urandom_range(0, 65535));
            if ($urandom_range(0, 7) == 0)
                s = $urandom_range(0, 1) ? '1 : '0;
            send_sample(s, 1'b0, '0);
        end

        in_valid = 1'b0;
        wait (pending_weights.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
